// ----- rtl/double_ended_queue_assert.svh -----
// assertion macros used by the checker of the deque
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, off while reset is held
`define DQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, off while reset is held
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque check failed");

// next-cycle implication checked at every edge, reset included
`define DQ_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// ----- rtl/dq_pkg.sv -----
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int DATA_W = 32;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [STAT_W-1:0] stat_t;

    localparam req_t REQ_PUSH_FRONT = 2'd0;
    localparam req_t REQ_PUSH_REAR  = 2'd1;
    localparam req_t REQ_POP_FRONT  = 2'd2;
    localparam req_t REQ_POP_REAR   = 2'd3;

    localparam stat_t STAT_OK    = 2'd0;
    localparam stat_t STAT_EMPTY = 2'd1;
    localparam stat_t STAT_FULL  = 2'd2;

endpackage

// ----- rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// a result beat passes the pending register and then the output register once its request beat is taken
// throughput: one request per cycle; the ring store takes one write or one
// registered read per request, and a request waits only while a result beat is stalled
// reset: rst_n clears the front and rear slots, the entry count and all valids;
// the ring store itself is not cleared, and no entry is read before it is written
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dq_pkg::REQ_W-1:0]        req_type,
    input  logic signed [dq_pkg::DATA_W-1:0] push_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [dq_pkg::DATA_W-1:0] pop_value,
    output logic [dq_pkg::STAT_W-1:0]       status,
    output logic [dq_pkg::OCC_W-1:0]        occupancy
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [dq_pkg::DATA_W-1:0] entry_mem [DEPTH];

    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] rear_reg, rear_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                      pend_valid_reg, pend_valid_next;
    dq_pkg::stat_t             pend_status_reg;
    logic [dq_pkg::OCC_W-1:0]  pend_occ_reg;
    logic                      pend_pop_reg;
    logic [dq_pkg::DATA_W-1:0] rd_data_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [dq_pkg::DATA_W-1:0] out_value_reg;
    dq_pkg::stat_t             out_status_reg;
    logic [dq_pkg::OCC_W-1:0]  out_occ_reg;

    logic          accept;
    logic          out_free;
    logic          pend_move;
    logic          wr_en;
    logic          rd_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    dq_pkg::stat_t req_status;

    logic [IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec;

    assign front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + IDX_W'(1);
    assign front_dec = (front_reg == '0) ? IDX_LAST : front_reg - IDX_W'(1);
    assign rear_inc  = (rear_reg == IDX_LAST) ? '0 : rear_reg + IDX_W'(1);
    assign rear_dec  = (rear_reg == '0) ? IDX_LAST : rear_reg - IDX_W'(1);

    // the pending beat leaves when the output register is empty or being taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign pend_move = pend_valid_reg && out_free;
    assign in_stall  = pend_valid_reg && !out_free;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = front_reg;
        rd_addr    = front_reg;
        req_status = dq_pkg::STAT_OK;
        unique case (req_type)
            dq_pkg::REQ_PUSH_FRONT,
            dq_pkg::REQ_PUSH_REAR:
            begin
                if (count_reg == CNT_FULL)
                begin
                    req_status = dq_pkg::STAT_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    count_next = count_reg + CNT_ONE;
                    if (count_reg == '0)
                    begin
                        rear_next = front_reg;
                        wr_addr   = front_reg;
                    end
                    else if (req_type == dq_pkg::REQ_PUSH_FRONT)
                    begin
                        front_next = front_dec;
                        wr_addr    = front_dec;
                    end
                    else
                    begin
                        rear_next = rear_inc;
                        wr_addr   = rear_inc;
                    end
                end
            end
            dq_pkg::REQ_POP_FRONT,
            dq_pkg::REQ_POP_REAR:
            begin
                if (count_reg == '0)
                begin
                    req_status = dq_pkg::STAT_EMPTY;
                end
                else
                begin
                    rd_en      = accept;
                    count_next = count_reg - CNT_ONE;
                    if (req_type == dq_pkg::REQ_POP_FRONT)
                    begin
                        rd_addr = front_reg;
                        if (count_reg != CNT_ONE)
                        begin
                            front_next = front_inc;
                        end
                    end
                    else
                    begin
                        rd_addr = rear_reg;
                        if (count_reg != CNT_ONE)
                        begin
                            rear_next = rear_dec;
                        end
                    end
                end
            end
            default:
            begin
                req_status = dq_pkg::STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            rear_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                count_reg <= count_next;
            end
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // one write or one read per beat, never both, so no same-entry collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= req_status;
            pend_occ_reg    <= dq_pkg::OCC_W'(count_next);
            pend_pop_reg    <= rd_en;
        end
        if (pend_move)
        begin
            out_value_reg  <= pend_pop_reg ? rd_data_reg : '0;
            out_status_reg <= pend_status_reg;
            out_occ_reg    <= pend_occ_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = out_value_reg;
    assign status    = out_status_reg;
    assign occupancy = out_occ_reg;

endmodule

// ----- rtl/dq_checker.sv -----
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"

module dq_checker #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic [dq_pkg::REQ_W-1:0]         req_type,
    input logic signed [dq_pkg::DATA_W-1:0] push_value,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [dq_pkg::DATA_W-1:0] pop_value,
    input logic [dq_pkg::STAT_W-1:0]        status,
    input logic [dq_pkg::OCC_W-1:0]         occupancy
);

    localparam logic [dq_pkg::OCC_W-1:0] OCC_FULL = dq_pkg::OCC_W'(DEPTH);

    logic [dq_pkg::DATA_W+dq_pkg::STAT_W+dq_pkg::OCC_W-1:0] out_bits;
    logic empty_beat;
    logic full_beat;
    logic zero_value;

    assign out_bits   = {pop_value, status, occupancy};
    assign empty_beat = out_valid && status == dq_pkg::STAT_EMPTY;
    assign full_beat  = out_valid && status == dq_pkg::STAT_FULL;
    assign zero_value = pop_value == '0;

    // a stalled result beat holds
    `DQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_bits))

    // with no result waiting, requests are never held off
    `DQ_ASSERT_NOW(a_no_idle_stall, clk, rst_n, !out_valid, !in_stall)

    // an empty pop leaves nothing held and returns zero
    `DQ_ASSERT_NOW(a_empty_pop, clk, rst_n, empty_beat, occupancy == '0 && zero_value)

    // a dropped push reports a full deque
    `DQ_ASSERT_NOW(a_full_push, clk, rst_n, full_beat, occupancy == OCC_FULL && zero_value)

    // reset clears the result side by the next edge
    `DQ_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
